// ===== design/ubuf_pkg.sv =====
// ----------------------------------------------------------------------------
// ubuf_pkg
// Types and constants shared by the buffered UART receive/transmit FIFOs.
// ----------------------------------------------------------------------------
package ubuf_pkg;

   localparam int RX_DEPTH = 64;
   localparam int TX_DEPTH = 64;
   localparam int RX_AW    = $clog2(RX_DEPTH);
   localparam int TX_AW    = $clog2(TX_DEPTH);

   // request function codes
   localparam logic [1:0] FUNC_LINE_RX  = 2'd0;
   localparam logic [1:0] FUNC_TX_READY = 2'd1;
   localparam logic [1:0] FUNC_SW_READ  = 2'd2;
   localparam logic [1:0] FUNC_SW_WRITE = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_in;
   } ubuf_req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       data_valid;
      logic       rejected;
      logic       rx_available;
      logic       rx_overflow;
      logic       tx_full_flag;
      logic       tx_request;
   } ubuf_rsp_type;

endpackage

// ===== design/ubuf_ram.sv =====
// ----------------------------------------------------------------------------
// ubuf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ubuf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/uart_buffered_rx_tx_fifos.sv =====
// ----------------------------------------------------------------------------
// uart_buffered_rx_tx_fifos
// Circular receive and transmit byte FIFOs behind an interrupt-driven UART.
// ----------------------------------------------------------------------------
//   channel   ports                     handshake
//   request   start, busy, req_data     taken when start high and busy low
//   response  rsp_strobe, rsp_data      one cycle, no back pressure
//
// A request is taken in any cycle; busy stays low. Its response shows in the
// next cycle, from the registered read port of the byte RAMs. Pointers
// and flags update at the accepting edge, so the next request sees them.
// Synchronous reset clears pointers and flags; RAM contents are not cleared.
module uart_buffered_rx_tx_fifos
   import ubuf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ubuf_req_type req_data,
   output logic         rsp_strobe,
   output ubuf_rsp_type rsp_data
);

   logic             accept;
   logic [RX_AW-1:0] rx_wp_ff, rx_wp_in, rx_rp_ff, rx_rp_in, rx_wp_bump, rx_rp_bump;
   logic [TX_AW-1:0] tx_wp_ff, tx_wp_in, tx_rp_ff, tx_rp_in, tx_wp_bump, tx_rp_bump;
   logic             avail_ff, avail_in, ovf_ff, ovf_in;
   logic             full_ff, full_in, txreq_ff, txreq_in;
   logic             strobe_ff, valid_ff, valid_in, rej_ff, rej_in, sel_tx_ff, sel_tx_in;
   logic             rx_we, rx_re, tx_we, tx_re;
   logic [7:0]       rx_q, tx_q;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign rx_wp_bump = (rx_wp_ff == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wp_ff + 1'b1;
   assign rx_rp_bump = (rx_rp_ff == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rp_ff + 1'b1;
   assign tx_wp_bump = (tx_wp_ff == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wp_ff + 1'b1;
   assign tx_rp_bump = (tx_rp_ff == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rp_ff + 1'b1;

   always_comb begin
      rx_wp_in  = rx_wp_ff;
      rx_rp_in  = rx_rp_ff;
      tx_wp_in  = tx_wp_ff;
      tx_rp_in  = tx_rp_ff;
      avail_in  = avail_ff;
      ovf_in    = ovf_ff;
      full_in   = full_ff;
      txreq_in  = txreq_ff;
      valid_in  = 1'b0;
      rej_in    = 1'b0;
      sel_tx_in = 1'b0;
      rx_we     = 1'b0;
      rx_re     = 1'b0;
      tx_we     = 1'b0;
      tx_re     = 1'b0;
      if (accept) begin
         case (req_data.func)
            FUNC_LINE_RX: begin
               // bytes are dropped silently while overflowed
               if (!ovf_ff) begin
                  rx_we    = 1'b1;
                  avail_in = 1'b1;
                  rx_wp_in = rx_wp_bump;
                  if (rx_wp_bump == rx_rp_ff) begin
                     ovf_in = 1'b1;
                  end
               end
            end
            FUNC_TX_READY: begin
               sel_tx_in = 1'b1;
               if (tx_wp_ff != tx_rp_ff || full_ff) begin
                  tx_re    = 1'b1;
                  valid_in = 1'b1;
                  full_in  = 1'b0;
                  tx_rp_in = tx_rp_bump;
               end else begin
                  txreq_in = 1'b0;
               end
            end
            FUNC_SW_READ: begin
               if (!avail_ff) begin
                  rej_in = 1'b1;
               end else begin
                  rx_re    = 1'b1;
                  valid_in = 1'b1;
                  ovf_in   = 1'b0;
                  rx_rp_in = rx_rp_bump;
                  if (rx_rp_bump == rx_wp_ff) begin
                     avail_in = 1'b0;
                  end
               end
            end
            FUNC_SW_WRITE: begin
               if (full_ff) begin
                  rej_in = 1'b1;
               end else begin
                  tx_we    = 1'b1;
                  tx_wp_in = tx_wp_bump;
                  txreq_in = 1'b1;
                  if (tx_wp_bump == tx_rp_ff) begin
                     full_in = 1'b1;
                  end
               end
            end
            default: begin
               rej_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wp_ff  <= '0;
         rx_rp_ff  <= '0;
         tx_wp_ff  <= '0;
         tx_rp_ff  <= '0;
         avail_ff  <= 1'b0;
         ovf_ff    <= 1'b0;
         full_ff   <= 1'b0;
         txreq_ff  <= 1'b0;
         strobe_ff <= 1'b0;
         valid_ff  <= 1'b0;
         rej_ff    <= 1'b0;
         sel_tx_ff <= 1'b0;
      end else begin
         rx_wp_ff  <= rx_wp_in;
         rx_rp_ff  <= rx_rp_in;
         tx_wp_ff  <= tx_wp_in;
         tx_rp_ff  <= tx_rp_in;
         avail_ff  <= avail_in;
         ovf_ff    <= ovf_in;
         full_ff   <= full_in;
         txreq_ff  <= txreq_in;
         strobe_ff <= accept;
         valid_ff  <= valid_in;
         rej_ff    <= rej_in;
         sel_tx_ff <= sel_tx_in;
      end
   end

   ubuf_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_we),
      .wr_addr (rx_wp_ff),
      .wr_data (req_data.data_in),
      .rd_en   (rx_re),
      .rd_addr (rx_rp_ff),
      .rd_data (rx_q)
   );

   ubuf_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_we),
      .wr_addr (tx_wp_ff),
      .wr_data (req_data.data_in),
      .rd_en   (tx_re),
      .rd_addr (tx_rp_ff),
      .rd_data (tx_q)
   );

   assign rsp_strobe = strobe_ff;

   always_comb begin
      rsp_data.data_out     = valid_ff ? (sel_tx_ff ? tx_q : rx_q) : 8'd0;
      rsp_data.data_valid   = valid_ff;
      rsp_data.rejected     = rej_ff;
      rsp_data.rx_available = avail_ff;
      rsp_data.rx_overflow  = ovf_ff;
      rsp_data.tx_full_flag = full_ff;
      rsp_data.tx_request   = txreq_ff;
   end

endmodule

// ===== design/ubuf_checker.sv =====
// ----------------------------------------------------------------------------
// ubuf_checker
// Port-level checks of the buffered UART FIFOs, bound to the top level.
// ----------------------------------------------------------------------------
module ubuf_checker
   import ubuf_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_strobe,
   input ubuf_rsp_type rsp_data
);

   // every request gets its response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("request without response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("response without request");

   a_valid_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.data_valid && rsp_data.rejected))
      else $error("byte delivered on a rejected request");

   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.data_valid) |-> rsp_data.data_out == 8'd0)
      else $error("data_out nonzero without a byte");

   // overflow only with a non-empty receive fifo
   a_ovf_avail: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.rx_overflow) |-> rsp_data.rx_available)
      else $error("overflow while rx empty");

endmodule

bind uart_buffered_rx_tx_fifos ubuf_checker u_ubuf_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
